/* hdl/tif_pkg.sv */
// ----------------------------------------------------------------------------
// tif_pkg
// Shared codes and types for the Telnet IAC filter: command bytes, parser
// modes, pending reply kinds and the parser-to-buffer emit record.
// ----------------------------------------------------------------------------
package tif_pkg;

    // telnet command bytes
    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] DATA_FF   = 8'hFF;

    // result destinations
    localparam logic DEST_APP  = 1'b0;
    localparam logic DEST_PEER = 1'b1;

    // parser mode
    typedef enum logic [2:0] {
        MODE_DATA    = 3'd0,
        MODE_CMD     = 3'd1,
        MODE_OPT     = 3'd2,
        MODE_SUB     = 3'd3,
        MODE_SUB_IAC = 3'd4
    } t_mode;

    // reply owed once the option byte arrives
    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_WONT = 2'd1,
        REPLY_DONT = 2'd2
    } t_reply;

    // what one input beat produces
    typedef struct packed {
        logic       data;    // one data byte to the application
        logic       reply;   // three-byte reply to the peer
        logic [7:0] verb;    // WONT or DONT for a reply
    } t_emit;

endpackage

/* hdl/tif_parser.sv */
// ----------------------------------------------------------------------------
// tif_parser
// Telnet command parser state machine. Looks at one byte per accepted beat,
// reports what that byte produces and advances the parse state.
// ----------------------------------------------------------------------------
module tif_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    output tif_pkg::t_emit  o_emit
);
    import tif_pkg::*;

    t_mode  r_mode, n_mode;
    t_reply r_reply, n_reply;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DATA;
            r_reply <= REPLY_NONE;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_reply <= n_reply;
        end
    end

    // next state and emit decode
    always_comb begin
        n_mode  = r_mode;
        n_reply = r_reply;
        o_emit  = '0;
        unique case (r_mode)
            MODE_CMD: begin
                priority if (i_byte == CODE_IAC) begin
                    o_emit.data = 1'b1;
                    n_mode      = MODE_DATA;
                end else if (i_byte == CODE_DO) begin
                    n_reply = REPLY_WONT;
                    n_mode  = MODE_OPT;
                end else if (i_byte == CODE_WILL) begin
                    n_reply = REPLY_DONT;
                    n_mode  = MODE_OPT;
                end else if (i_byte == CODE_WONT || i_byte == CODE_DONT) begin
                    n_reply = REPLY_NONE;
                    n_mode  = MODE_OPT;
                end else if (i_byte == CODE_SB) begin
                    n_mode = MODE_SUB;
                end else begin
                    n_mode = MODE_DATA;
                end
            end
            MODE_OPT: begin
                if (r_reply == REPLY_WONT || r_reply == REPLY_DONT) begin
                    o_emit.reply = 1'b1;
                    o_emit.verb  = (r_reply == REPLY_WONT) ? CODE_WONT : CODE_DONT;
                end
                n_reply = REPLY_NONE;
                n_mode  = MODE_DATA;
            end
            MODE_SUB: begin
                if (i_byte == CODE_IAC) begin
                    n_mode = MODE_SUB_IAC;
                end
            end
            MODE_SUB_IAC: begin
                n_mode = (i_byte == CODE_SE) ? MODE_DATA : MODE_SUB;
            end
            default: begin
                // plain data, also covers unused mode codes
                if (i_byte == CODE_IAC) begin
                    n_mode = MODE_CMD;
                end else begin
                    o_emit.data = 1'b1;
                    n_mode      = MODE_DATA;
                end
            end
        endcase
    end

endmodule

/* hdl/telnet_iac_filter_unit.sv */
// ----------------------------------------------------------------------------
// telnet_iac_filter_unit
// Telnet IAC stripper with option refusal: data bytes to the application,
// WONT/DONT replies to the peer, on one tagged output stream.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while o_stall is low. Each byte
// yields no beat, one data beat (dest 0), or a three-beat reply IAC WONT/DONT
// x (dest 1) once the option byte of IAC DO x or IAC WILL x arrives. The
// result buffer holds one item's beats; a new byte is taken when it is empty
// or its last beat leaves in the same cycle, so data flows at one byte per
// cycle while i_stall is low, and a reply holds input until its last beat
// leaves. Output is registered. last_of_run marks each byte's final beat.
module telnet_iac_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // received byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import tif_pkg::*;

    t_emit      w_emit;
    logic       w_take;
    logic       w_out_fire;
    logic [1:0] r_cnt, n_cnt;
    logic       r_reply;
    logic [7:0] r_verb;
    logic [7:0] r_byte;

    // handshake
    assign w_out_fire = o_valid && !i_stall;
    assign o_stall    = !((r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_stall));
    assign w_take     = i_valid && !o_stall;

    tif_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_in_byte),
        .o_emit  (w_emit)
    );

    // beats left in the result buffer
    always_comb begin
        n_cnt = r_cnt;
        if (w_take) begin
            if (w_emit.reply) begin
                n_cnt = 2'd3;
            end else if (w_emit.data) begin
                n_cnt = 2'd1;
            end else begin
                n_cnt = 2'd0;
            end
        end else if (w_out_fire) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_reply <= w_emit.reply;
            r_verb  <= w_emit.verb;
            r_byte  <= w_emit.data ? ((i_in_byte == CODE_IAC) ? DATA_FF : i_in_byte)
                                   : i_in_byte;
        end
    end

    // output beat select
    assign o_valid       = (r_cnt != 2'd0);
    assign o_dest        = r_reply ? DEST_PEER : DEST_APP;
    assign o_last_of_run = (r_cnt == 2'd1);
    always_comb begin
        unique case (r_cnt)
            2'd3:    o_out_byte = r_reply ? CODE_IAC : r_byte;
            2'd2:    o_out_byte = r_reply ? r_verb : r_byte;
            default: o_out_byte = r_byte;
        endcase
    end

endmodule

/* tb/telnet_iac_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// telnet_iac_filter_unit_tb
// Self-checking bench for the Telnet IAC filter. A directed table covers
// plain data, escaped 0xFF, DO/WILL refusals, WONT/DONT, dropped commands and
// subnegotiation. Random well-formed command traffic mixed with noise follows.
// Each beat is checked against a bench-side parser model or a typed row value.
// ----------------------------------------------------------------------------
module telnet_iac_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tif_pkg::*;

    // one output beat
    typedef struct packed {
        logic       dest;
        logic [7:0] octet;
        logic       last;
    } t_beat;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       fixed_exp;   // expectation typed in the row
        logic       fixed_beat;  // typed row yields one data beat
        logic [7:0] octet;       // value of that data beat
    } t_row;

    localparam logic [7:0] CMD_NOP     = 8'hF1;
    localparam int         HOLD_CYCLES = 60;
    localparam int         MAX_REPORTS = 10;

    // directed table: data extremes, escaped 0xFF, every verb, subnegotiation
    localparam t_row SCRIPT [26] = '{
        '{8'h00,     1'b1, 1'b1, 8'h00},
        '{8'hFE,     1'b1, 1'b1, 8'hFE},
        '{CODE_IAC,  1'b1, 1'b0, 8'h00},
        '{CODE_IAC,  1'b1, 1'b1, DATA_FF},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_DO,   1'b0, 1'b0, 8'h00},
        '{8'h00,     1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_WILL, 1'b0, 1'b0, 8'h00},
        '{8'hFF,     1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_WONT, 1'b0, 1'b0, 8'h00},
        '{8'h05,     1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_DONT, 1'b0, 1'b0, 8'h00},
        '{8'h06,     1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_SB,   1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{8'h00,     1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CODE_SE,   1'b0, 1'b0, 8'h00},
        '{CODE_IAC,  1'b0, 1'b0, 8'h00},
        '{CMD_NOP,   1'b0, 1'b0, 8'h00}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_dest;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    // parser model state
    t_mode  model_mode  = MODE_DATA;
    t_reply model_reply = REPLY_NONE;

    t_beat      beats_due [$];
    logic [7:0] rx_stream [$];
    int         err_cnt       = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req      = 1'b0;
    int         hold_left     = 0;

    telnet_iac_filter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_dest        (o_dest),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parse one received byte, return the beats it causes
    function automatic int parse_byte(input logic [7:0] b, output t_beat r [3]);
        int n;
        n = 0;
        r[0] = '0;
        r[1] = '0;
        r[2] = '0;
        case (model_mode)
            MODE_CMD: begin
                if (b == CODE_IAC) begin
                    r[0] = '{DEST_APP, DATA_FF, 1'b1};
                    n = 1;
                    model_mode = MODE_DATA;
                end else if (b == CODE_DO) begin
                    model_reply = REPLY_WONT;
                    model_mode  = MODE_OPT;
                end else if (b == CODE_WILL) begin
                    model_reply = REPLY_DONT;
                    model_mode  = MODE_OPT;
                end else if (b == CODE_WONT || b == CODE_DONT) begin
                    model_reply = REPLY_NONE;
                    model_mode  = MODE_OPT;
                end else if (b == CODE_SB) begin
                    model_mode = MODE_SUB;
                end else begin
                    model_mode = MODE_DATA;
                end
            end
            MODE_OPT: begin
                // refusal goes out once the option byte is known
                if (model_reply == REPLY_WONT || model_reply == REPLY_DONT) begin
                    r[0] = '{DEST_PEER, CODE_IAC, 1'b0};
                    r[1] = '{DEST_PEER,
                             (model_reply == REPLY_WONT) ? CODE_WONT : CODE_DONT, 1'b0};
                    r[2] = '{DEST_PEER, b, 1'b1};
                    n = 3;
                end
                model_reply = REPLY_NONE;
                model_mode  = MODE_DATA;
            end
            MODE_SUB: begin
                if (b == CODE_IAC) model_mode = MODE_SUB_IAC;
            end
            MODE_SUB_IAC: begin
                model_mode = (b == CODE_SE) ? MODE_DATA : MODE_SUB;
            end
            default: begin
                if (b == CODE_IAC) begin
                    model_mode = MODE_CMD;
                end else begin
                    r[0] = '{DEST_APP, b, 1'b1};
                    n = 1;
                    model_mode = MODE_DATA;
                end
            end
        endcase
        return n;
    endfunction

    // offer one byte, called at a falling edge, returns at a falling edge
    task automatic offer_byte(input logic [7:0] b, input logic fixed_exp,
                              input logic fixed_beat, input logic [7:0] octet);
        t_beat r [3];
        int    n;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n = parse_byte(b, r);
        if (fixed_exp) begin
            if (fixed_beat) beats_due.push_back('{DEST_APP, octet, 1'b1});
        end else begin
            for (int k = 0; k < n; k++) beats_due.push_back(r[k]);
        end
        @(negedge i_clk);
    endtask

    // hold the sender until every expected beat is out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random traffic: plain data, escapes and well-formed commands, some raw noise
    task automatic run_traffic(input int count);
        int kind;
        int len;
        rx_stream.delete();
        while (rx_stream.size() < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                rx_stream.push_back(8'($urandom_range(0, 254)));
            end else if (kind < 45) begin
                rx_stream.push_back(CODE_IAC);
                rx_stream.push_back(CODE_IAC);
            end else if (kind < 60) begin
                rx_stream.push_back(CODE_IAC);
                rx_stream.push_back($urandom_range(0, 1) ? CODE_DO : CODE_WILL);
                rx_stream.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 68) begin
                rx_stream.push_back(CODE_IAC);
                rx_stream.push_back($urandom_range(0, 1) ? CODE_WONT : CODE_DONT);
                rx_stream.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 78) begin
                rx_stream.push_back(CODE_IAC);
                rx_stream.push_back(CODE_SB);
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++) begin
                    rx_stream.push_back(8'($urandom_range(0, 255)));
                end
                rx_stream.push_back(CODE_IAC);
                rx_stream.push_back(CODE_SE);
            end else if (kind < 85) begin
                rx_stream.push_back(CODE_IAC);
                rx_stream.push_back(8'($urandom_range(0, 249)));
            end else begin
                rx_stream.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (rx_stream[k]) offer_byte(rx_stream[k], 1'b0, 1'b0, 8'h00);
    endtask

    // receiver back-pressure, with one long hold on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (beats_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("unexpected beat: dest %0d byte %02h last %0d",
                             o_dest, o_out_byte, o_last_of_run);
                end
            end else begin
                want = beats_due.pop_front();
                if (o_dest !== want.dest || o_out_byte !== want.octet ||
                    o_last_of_run !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("mismatch: want dest %0d byte %02h last %0d, got %0d %02h %0d",
                                 want.dest, want.octet, want.last,
                                 o_dest, o_out_byte, o_last_of_run);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("telnet_iac_filter_unit_tb: errors");
        $finish;
    end

    // main sequence
    initial begin
        send_idle_pct = 38;
        recv_idle_pct = 82;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (SCRIPT[i]) begin
            offer_byte(SCRIPT[i].rx_byte, SCRIPT[i].fixed_exp,
                       SCRIPT[i].fixed_beat, SCRIPT[i].octet);
        end
        wait_drained();

        run_traffic(120);
        wait_drained();

        send_idle_pct = 82;
        recv_idle_pct = 38;
        run_traffic(120);
        wait_drained();

        // no idling, but a long receiver hold to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_traffic(120);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("telnet_iac_filter_unit_tb: clean");
        end else begin
            $display("telnet_iac_filter_unit_tb: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/tif_pkg.sv
hdl/tif_parser.sv
hdl/telnet_iac_filter_unit.sv
tb/telnet_iac_filter_unit_tb.sv
